// ===== hw/rtl/plgh_pkg.sv =====
// ----------------------------------------------------------------------------
// plgh_pkg: shared types and constants for the polyline ground height query
// Request payloads, result payloads, register map and the microcode ROM.
// ----------------------------------------------------------------------------
package plgh_pkg;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int HEIGHT_W = 23;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = 5;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int COUNT_W = 6;
    localparam logic       REG_POINT_COUNT   = 1'b0;
    localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 6'd2;

    // Saturation limits of a signed Q16.8 value
    localparam logic signed [COORD_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] S24_MIN = 24'sh800000;

    // Request actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                       action;
        logic [4:0]                 point_index;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic [HEIGHT_W-1:0]        box_height;
    } t_in_item;

    typedef struct packed {
        logic                       segment_found;
        logic                       hit;
        logic                       inside_span;
        logic signed [COORD_W-1:0]  surface_y;
        logic signed [COORD_W-1:0]  resolved_y;
    } t_out_item;

    // Microcode addresses
    typedef logic [3:0] t_upc;
    localparam t_upc UPC_IDLE  = 4'd0;
    localparam t_upc UPC_DISP  = 4'd1;
    localparam t_upc UPC_LOAD0 = 4'd2;
    localparam t_upc UPC_SPAN  = 4'd3;
    localparam t_upc UPC_CMP   = 4'd4;
    localparam t_upc UPC_TEST  = 4'd5;
    localparam t_upc UPC_MUL   = 4'd6;
    localparam t_upc UPC_DIVGO = 4'd7;
    localparam t_upc UPC_WAIT  = 4'd8;
    localparam t_upc UPC_FIN   = 4'd9;
    localparam t_upc UPC_WR    = 4'd10;
    localparam t_upc UPC_NONE  = 4'd11;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_LATCH = 4'd1,
        OP_CLEAR = 4'd2,
        OP_LOAD0 = 4'd3,
        OP_SPAN  = 4'd4,
        OP_CMP   = 4'd5,
        OP_MUL   = 4'd6,
        OP_DIVGO = 4'd7,
        OP_FIN   = 4'd8,
        OP_WRITE = 4'd9,
        OP_NONE  = 4'd10
    } t_op;

    // Table read address select
    typedef enum logic [1:0] {
        ADDR_ZERO  = 2'd0,
        ADDR_LAST  = 2'd1,
        ADDR_NEXT  = 2'd2,
        ADDR_NEXT2 = 2'd3
    } t_addr_sel;

    // Jump conditions
    typedef enum logic [2:0] {
        C_TRUE     = 3'd0,
        C_IN_ACC   = 3'd1,
        C_IS_WRITE = 3'd2,
        C_SCAN     = 3'd3,
        C_FOUND    = 3'd4,
        C_DIV_BUSY = 3'd5,
        C_OUT_BUSY = 3'd6
    } t_cond;

    typedef struct packed {
        logic       in_ready;
        t_addr_sel  addr;
        t_op        op;
        t_cond      cond;
        t_upc       jt;   // target when condition holds
        t_upc       jf;   // target otherwise
    } t_uword;

    // Microcode ROM
    function automatic t_uword ucode_rom(input t_upc a);
        t_uword w;
        unique case (a)
            UPC_IDLE:  w = '{1'b1, ADDR_ZERO,  OP_LATCH, C_IN_ACC,   UPC_DISP,  UPC_IDLE};
            UPC_DISP:  w = '{1'b0, ADDR_ZERO,  OP_CLEAR, C_IS_WRITE, UPC_WR,    UPC_LOAD0};
            UPC_LOAD0: w = '{1'b0, ADDR_LAST,  OP_LOAD0, C_TRUE,     UPC_SPAN,  UPC_SPAN};
            UPC_SPAN:  w = '{1'b0, ADDR_NEXT,  OP_SPAN,  C_TRUE,     UPC_CMP,   UPC_CMP};
            UPC_CMP:   w = '{1'b0, ADDR_NEXT2, OP_CMP,   C_SCAN,     UPC_CMP,   UPC_TEST};
            UPC_TEST:  w = '{1'b0, ADDR_ZERO,  OP_NOP,   C_FOUND,    UPC_MUL,   UPC_NONE};
            UPC_MUL:   w = '{1'b0, ADDR_ZERO,  OP_MUL,   C_TRUE,     UPC_DIVGO, UPC_DIVGO};
            UPC_DIVGO: w = '{1'b0, ADDR_ZERO,  OP_DIVGO, C_TRUE,     UPC_WAIT,  UPC_WAIT};
            UPC_WAIT:  w = '{1'b0, ADDR_ZERO,  OP_NOP,   C_DIV_BUSY, UPC_WAIT,  UPC_FIN};
            UPC_FIN:   w = '{1'b0, ADDR_ZERO,  OP_FIN,   C_OUT_BUSY, UPC_FIN,   UPC_IDLE};
            UPC_WR:    w = '{1'b0, ADDR_ZERO,  OP_WRITE, C_OUT_BUSY, UPC_WR,    UPC_IDLE};
            UPC_NONE:  w = '{1'b0, ADDR_ZERO,  OP_NONE,  C_OUT_BUSY, UPC_NONE,  UPC_IDLE};
            default:   w = '{1'b0, ADDR_ZERO,  OP_NOP,   C_TRUE,     UPC_IDLE,  UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/plgh_div.sv =====
// ----------------------------------------------------------------------------
// plgh_div: serial restoring divider
// Divides a 48-bit magnitude by a 24-bit divisor, one quotient bit per cycle.
// The caller guarantees the quotient fits in 24 bits.
// ----------------------------------------------------------------------------
module plgh_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [plgh_pkg::PROD_W-1:0]      i_dividend,
    input  logic [plgh_pkg::COORD_W-1:0]     i_divisor,
    output logic                             o_busy,
    output logic [plgh_pkg::COORD_W-1:0]     o_quotient
);

    logic [plgh_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [plgh_pkg::COORD_W-1:0]   r_rem;
    logic [plgh_pkg::COORD_W-1:0]   r_lo;
    logic [plgh_pkg::COORD_W-1:0]   r_div;
    logic [plgh_pkg::COORD_W:0]     shifted;
    logic [plgh_pkg::COORD_W:0]     diff;
    logic                           ge;

    // One restoring step
    assign shifted = {r_rem, r_lo[plgh_pkg::COORD_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = (shifted >= {1'b0, r_div});

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= plgh_pkg::DIV_CNT_W'(plgh_pkg::DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - plgh_pkg::DIV_CNT_W'(1);
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[plgh_pkg::PROD_W-1:plgh_pkg::COORD_W];
            r_lo  <= i_dividend[plgh_pkg::COORD_W-1:0];
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[plgh_pkg::COORD_W-1:0] : shifted[plgh_pkg::COORD_W-1:0];
            r_lo  <= {r_lo[plgh_pkg::COORD_W-2:0], ge};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_lo;

endmodule

// ===== hw/rtl/polyline_ground_height_query_top.sv =====
// ----------------------------------------------------------------------------
// polyline_ground_height_query_top: ground height lookup on a polyline
// Breakpoint table, microcoded segment search, interpolation and resolve.
// ----------------------------------------------------------------------------
// A write request stores one breakpoint and returns an all-zero result. A
// query scans the segments from the first until one spans x or the last one
// is reached; the segment scan reads one table entry per cycle through the
// table read port, and a found segment is then interpolated through the serial
// divider. One request is in flight at a time; a finished result waits in an
// output register while the next request is taken. No clearing pass after
// reset; the point count resets to 2.
module polyline_ground_height_query_top #(
    parameter int MAX_POINTS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  plgh_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output plgh_pkg::t_out_item              o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [plgh_pkg::PADDR_W-1:0]     paddr,
    input  logic [plgh_pkg::PDATA_W-1:0]     pwdata,
    output logic [plgh_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = IW + 1;
    localparam int W  = plgh_pkg::COORD_W;

    // Breakpoint tables
    logic signed [W-1:0] r_x_mem [MAX_POINTS];
    logic signed [W-1:0] r_y_mem [MAX_POINTS];

    // Sequencer and datapath registers
    plgh_pkg::t_upc      r_upc;
    plgh_pkg::t_upc      n_upc;
    plgh_pkg::t_uword    uw;
    plgh_pkg::t_in_item  r_item;
    logic [IW-1:0]       r_i;
    logic                r_found;
    logic                r_inside;
    logic signed [W-1:0] r_xa, r_ya, r_xb, r_yb;
    logic signed [W-1:0] r_rx, r_ry;
    logic [plgh_pkg::PROD_W-1:0] r_prod;
    logic [W-1:0]        r_dx;
    logic                r_neg;
    logic [plgh_pkg::COUNT_W-1:0] r_point_count;
    plgh_pkg::t_out_item r_out;
    logic                r_out_valid;

    // Combinational signals
    int                  cnt_sat;
    logic [CW-1:0]       n_use;
    logic [IW-1:0]       last_seg;
    logic [CW-1:0]       rd_addr;
    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic                seg_hit;
    logic                is_last;
    logic                cond;
    logic signed [W:0]   dy, off, dx;
    logic [W:0]          dy_neg;
    logic [W-1:0]        dy_mag;
    logic [plgh_pkg::PROD_W-1:0] prod;
    logic                div_busy;
    logic [W-1:0]        div_q;
    logic signed [W:0]   q_s;
    logic signed [W:0]   surface;
    logic signed [W-1:0] surf24;
    logic [21:0]         half;
    logic signed [W+1:0] surf26, foot, res26;
    logic                hit;
    logic signed [W-1:0] res_sat;
    plgh_pkg::t_out_item out_val;

    assign uw = plgh_pkg::ucode_rom(r_upc);

    // Breakpoints in use, held to 2..MAX_POINTS
    always_comb begin
        cnt_sat = int'(r_point_count);
        if (cnt_sat < 2) cnt_sat = 2;
        if (cnt_sat > MAX_POINTS) cnt_sat = MAX_POINTS;
        n_use = CW'(cnt_sat);
    end
    assign last_seg = IW'(n_use - CW'(2));

    // Table read address
    always_comb begin
        case (uw.addr)
            plgh_pkg::ADDR_ZERO:  rd_addr = '0;
            plgh_pkg::ADDR_LAST:  rd_addr = n_use - CW'(1);
            plgh_pkg::ADDR_NEXT:  rd_addr = {1'b0, r_i} + CW'(1);
            plgh_pkg::ADDR_NEXT2: rd_addr = {1'b0, r_i} + CW'(2);
            default:              rd_addr = '0;
        endcase
    end

    // Handshakes
    assign o_in_ready = uw.in_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = ((uw.op == plgh_pkg::OP_FIN) || (uw.op == plgh_pkg::OP_WRITE) ||
                         (uw.op == plgh_pkg::OP_NONE)) && out_free;

    // Segment test against the entry just read
    assign seg_hit = (r_item.coord_x >= r_xa) && (r_item.coord_x < r_rx);
    assign is_last = (r_i == last_seg);

    // Jump condition
    always_comb begin
        case (uw.cond)
            plgh_pkg::C_TRUE:     cond = 1'b1;
            plgh_pkg::C_IN_ACC:   cond = in_acc;
            plgh_pkg::C_IS_WRITE: cond = (r_item.action == plgh_pkg::ACT_WRITE);
            plgh_pkg::C_SCAN:     cond = !seg_hit && !is_last;
            plgh_pkg::C_FOUND:    cond = r_found;
            plgh_pkg::C_DIV_BUSY: cond = div_busy;
            plgh_pkg::C_OUT_BUSY: cond = !out_free;
            default:              cond = 1'b1;
        endcase
    end
    assign n_upc = cond ? uw.jt : uw.jf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= plgh_pkg::UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (uw.op == plgh_pkg::OP_WRITE && out_free &&
            int'(r_item.point_index) < MAX_POINTS) begin
            r_x_mem[IW'(r_item.point_index)] <= r_item.coord_x;
            r_y_mem[IW'(r_item.point_index)] <= r_item.coord_y;
        end
        if (int'(rd_addr) < MAX_POINTS) begin
            r_rx <= r_x_mem[rd_addr[IW-1:0]];
            r_ry <= r_y_mem[rd_addr[IW-1:0]];
        end
    end

    // Interpolation product operands
    assign dy     = {r_yb[W-1], r_yb} - {r_ya[W-1], r_ya};
    assign dy_neg = -dy;
    assign dy_mag = dy[W] ? dy_neg[W-1:0] : dy[W-1:0];
    assign off    = {r_item.coord_x[W-1], r_item.coord_x} - {r_xa[W-1], r_xa};
    assign dx     = {r_xb[W-1], r_xb} - {r_xa[W-1], r_xa};
    assign prod   = dy_mag * off[W-1:0];

    // Datapath operations
    always_ff @(posedge i_clk) begin
        case (uw.op)
            plgh_pkg::OP_LATCH: begin
                if (in_acc) r_item <= i_in_item;
            end
            plgh_pkg::OP_CLEAR: begin
                r_i     <= '0;
                r_found <= 1'b0;
            end
            plgh_pkg::OP_LOAD0: begin
                r_xa <= r_rx;
                r_ya <= r_ry;
            end
            plgh_pkg::OP_SPAN: begin
                r_inside <= (r_item.coord_x >= r_xa) && (r_item.coord_x <= r_rx);
            end
            plgh_pkg::OP_CMP: begin
                if (seg_hit) begin
                    r_found <= 1'b1;
                    r_xb    <= r_rx;
                    r_yb    <= r_ry;
                end else begin
                    r_xa <= r_rx;
                    r_ya <= r_ry;
                    r_i  <= r_i + IW'(1);
                end
            end
            plgh_pkg::OP_MUL: begin
                r_prod <= prod;
                r_dx   <= dx[W-1:0];
                r_neg  <= dy[W];
            end
            default: ;
        endcase
    end

    // Serial divide of the product by the segment width
    plgh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (uw.op == plgh_pkg::OP_DIVGO),
        .i_dividend (r_prod),
        .i_divisor  (r_dx),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // Surface, hit test and saturated resolve
    assign q_s     = r_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign surface = {r_ya[W-1], r_ya} + q_s;
    assign surf24  = surface[W-1:0];
    assign half    = r_item.box_height[plgh_pkg::HEIGHT_W-1:1];
    assign surf26  = {{2{surf24[W-1]}}, surf24};
    assign foot    = {{2{r_item.coord_y[W-1]}}, r_item.coord_y} - $signed({4'b0, half});
    assign res26   = surf26 + $signed({4'b0, half});
    assign hit     = (surf26 >= foot);

    always_comb begin
        if (res26[W+1:W-1] != {3{res26[W-1]}}) begin
            res_sat = res26[W+1] ? plgh_pkg::S24_MIN : plgh_pkg::S24_MAX;
        end else begin
            res_sat = res26[W-1:0];
        end
    end

    // Result selection
    always_comb begin
        out_val = '0;
        case (uw.op)
            plgh_pkg::OP_FIN: begin
                out_val.segment_found = 1'b1;
                out_val.hit           = hit;
                out_val.inside_span   = r_inside;
                out_val.surface_y     = surf24;
                out_val.resolved_y    = res_sat;
            end
            plgh_pkg::OP_NONE: begin
                out_val.inside_span   = r_inside;
                out_val.resolved_y    = r_item.coord_y;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= out_val;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= plgh_pkg::POINT_COUNT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == plgh_pkg::REG_POINT_COUNT) begin
            r_point_count <= pwdata[plgh_pkg::COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == plgh_pkg::REG_POINT_COUNT) ?
                    plgh_pkg::PDATA_W'(r_point_count) : '0;

    // Divider runs only while the sequencer waits on it
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_upc == plgh_pkg::UPC_WAIT))
        else $error("divider busy outside wait step");

    // A found segment lies inside the breakpoints in use
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == plgh_pkg::UPC_TEST && r_found) |-> (r_i <= last_seg))
        else $error("segment index past last segment");

    // Quotient must fit: upper dividend half below a nonzero divisor
    a_div_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == plgh_pkg::UPC_DIVGO) |->
        (r_dx != '0 && r_prod[plgh_pkg::PROD_W-1:W] < r_dx))
        else $error("divide operands out of range");

    // Write and query paths follow the latched action
    a_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_upc == plgh_pkg::UPC_WR) |-> (r_item.action == plgh_pkg::ACT_WRITE)) and
        ((r_upc == plgh_pkg::UPC_TEST) |-> (r_item.action == plgh_pkg::ACT_QUERY)))
        else $error("sequencer path does not match request action");

endmodule

// ===== dv/plgh_height_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plgh_height_checker: result checker for the polyline ground height query
// Watches the request, result and register ports, keeps its own breakpoint
// table and point count, predicts every result and compares it in order.
// ----------------------------------------------------------------------------
module plgh_height_checker #(
    parameter int MAX_POINTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  plgh_pkg::t_in_item           i_in_item,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  plgh_pkg::t_out_item          i_out_item,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [plgh_pkg::PADDR_W-1:0] i_paddr,
    input  logic [plgh_pkg::PDATA_W-1:0] i_pwdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending
);

    // Shadow copy of the breakpoint table and the point count register
    logic signed [plgh_pkg::COORD_W-1:0] bp_x [MAX_POINTS];
    logic signed [plgh_pkg::COORD_W-1:0] bp_y [MAX_POINTS];
    logic [plgh_pkg::COUNT_W-1:0]        point_count = plgh_pkg::POINT_COUNT_RESET;
    plgh_pkg::t_out_item                 expected_heights [$];
    int                                  fail_total = 0;

    // Applies one request: stores a breakpoint, or looks up the ground height
    function automatic plgh_pkg::t_out_item resolve_request(input plgh_pkg::t_in_item req);
        plgh_pkg::t_out_item res;
        int        n;
        longint    px, py, half, xa, xb, ya, yb, surf, resolved;
        res = '0;
        if (req.action == plgh_pkg::ACT_WRITE) begin
            if (req.point_index < MAX_POINTS) begin
                bp_x[req.point_index] = req.coord_x;
                bp_y[req.point_index] = req.coord_y;
            end
            return res;
        end
        // count in use is saturated to 2..MAX_POINTS
        n = (point_count < 2) ? 2 : ((point_count > MAX_POINTS) ? MAX_POINTS : point_count);
        px = longint'(req.coord_x);
        py = longint'(req.coord_y);
        half = longint'(req.box_height >> 1);
        surf = 0;
        resolved = py;
        // first segment with x[i] <= px < x[i+1]
        for (int i = 0; i + 1 < n; i++) begin
            xa = longint'(bp_x[i]);
            xb = longint'(bp_x[i + 1]);
            if (px >= xa && px < xb) begin
                ya = longint'(bp_y[i]);
                yb = longint'(bp_y[i + 1]);
                // signed division truncates toward zero
                surf = ya + ((yb - ya) * (px - xa)) / (xb - xa);
                res.segment_found = 1'b1;
                break;
            end
        end
        if (res.segment_found) begin
            res.hit = (surf >= py - half);
            resolved = surf + half;
            if (resolved > longint'(plgh_pkg::S24_MAX))
                resolved = longint'(plgh_pkg::S24_MAX);
            if (resolved < longint'(plgh_pkg::S24_MIN))
                resolved = longint'(plgh_pkg::S24_MIN);
        end
        res.inside_span = (px >= longint'(bp_x[0])) && (px <= longint'(bp_x[n - 1]));
        res.surface_y = plgh_pkg::COORD_W'(surf);
        res.resolved_y = plgh_pkg::COORD_W'(resolved);
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Monitor: register writes, accepted results, accepted requests
    always @(posedge i_clk) begin : monitor
        plgh_pkg::t_out_item want;
        if (!i_rst_n) begin
            point_count = plgh_pkg::POINT_COUNT_RESET;
            expected_heights.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == plgh_pkg::PADDR_W'(4 * plgh_pkg::REG_POINT_COUNT)) begin
                point_count = i_pwdata[plgh_pkg::COUNT_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_heights.size() == 0) begin
                    note_failure($sformatf("result with no request pending: %p", i_out_item));
                end else begin
                    want = expected_heights.pop_front();
                    if (want.segment_found !== i_out_item.segment_found
                        || want.hit !== i_out_item.hit
                        || want.inside_span !== i_out_item.inside_span
                        || want.surface_y !== i_out_item.surface_y
                        || want.resolved_y !== i_out_item.resolved_y) begin
                        note_failure($sformatf(
                            {"result mismatch: expected found=%0d hit=%0d inside=%0d ",
                             "surface=%0d resolved=%0d, got found=%0d hit=%0d inside=%0d ",
                             "surface=%0d resolved=%0d"},
                            want.segment_found, want.hit, want.inside_span,
                            want.surface_y, want.resolved_y,
                            i_out_item.segment_found, i_out_item.hit,
                            i_out_item.inside_span, i_out_item.surface_y,
                            i_out_item.resolved_y));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_heights.push_back(resolve_request(i_in_item));
            end
        end
        o_pending <= expected_heights.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the polyline ground height query
// Drives breakpoint writes and height queries with random idling on both
// channels, programs the point count between phases, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_POINTS = 32;
    localparam int IDLE_PCT   = 21;
    localparam int NUM_ITEMS  = 1800;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    plgh_pkg::t_in_item           i_in_item = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    plgh_pkg::t_out_item          o_out_item;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [plgh_pkg::PADDR_W-1:0] paddr = '0;
    logic [plgh_pkg::PDATA_W-1:0] pwdata = '0;
    logic [plgh_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    int fail_count;
    int pending_results;
    int idle_pct = IDLE_PCT;
    int requests_sent = 0;

    // Breakpoints as last written, used to aim queries at the polyline
    int bp_x_stim [MAX_POINTS];
    int bp_y_stim [MAX_POINTS];

    polyline_ground_height_query_top #(
        .MAX_POINTS (MAX_POINTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    plgh_height_checker #(
        .MAX_POINTS (MAX_POINTS)
    ) height_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic int rand_coord();
        return int'($urandom_range(0, 16777215)) - 8388608;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v > 8388607) ? 8388607 : ((v < -8388608) ? -8388608 : v);
    endfunction

    // Presents one request and holds it until accepted
    task automatic send_request(input plgh_pkg::t_in_item req);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic put_point(input int idx, input int x, input int y);
        plgh_pkg::t_in_item req;
        req = '0;
        req.action = plgh_pkg::ACT_WRITE;
        req.point_index = 5'(idx);
        req.coord_x = plgh_pkg::COORD_W'(x);
        req.coord_y = plgh_pkg::COORD_W'(y);
        req.box_height = plgh_pkg::HEIGHT_W'($urandom_range(0, 8388607));
        if (idx < MAX_POINTS) begin
            bp_x_stim[idx] = x;
            bp_y_stim[idx] = y;
        end
        send_request(req);
    endtask

    task automatic ask_height(input int x, input int y, input int h);
        plgh_pkg::t_in_item req;
        req.action = plgh_pkg::ACT_QUERY;
        req.point_index = 5'($urandom_range(0, 31));
        req.coord_x = plgh_pkg::COORD_W'(x);
        req.coord_y = plgh_pkg::COORD_W'(y);
        req.box_height = plgh_pkg::HEIGHT_W'(h);
        send_request(req);
    endtask

    // Drops valid, waits for all results, then lets the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle; upper bits are junk
    task automatic set_point_count(input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= plgh_pkg::PADDR_W'(4 * plgh_pkg::REG_POINT_COUNT);
        pwdata <= {26'($urandom), 6'(value)};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin : stimulus
        int phase, cfg, n, step_max, step, x, y, seg, lo, hi, px, py, h, r, nq;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset count of two: extreme breakpoints, saturation, end of span
        put_point(0, -8388608, -8388608);
        put_point(1, 8388607, 8388607);
        ask_height(-8388608, 0, 0);
        ask_height(8388607, 0, 0);
        ask_height(8388606, 0, 8388607);
        ask_height(0, -8388608, 8388607);
        settle();

        // Four points: negative slope, zero-width segment, below the first and at the last breakpoint
        set_point_count(4);
        put_point(0, -1024, 512);
        put_point(1, 0, -300);
        put_point(2, 0, 77);
        put_point(3, 1000, -1);
        put_point(31, 8388607, -8388608);
        ask_height(-1, -299, 2);
        ask_height(-1, -298, 0);
        ask_height(0, 100, 46);
        ask_height(1000, 5, 7);
        ask_height(-1025, 0, 1);
        settle();

        // Count below range saturates to two
        set_point_count(1);
        ask_height(-512, 0, 0);
        ask_height(500, 0, 3);

        // Random phases: fresh non-decreasing polyline, then queries and stray writes
        phase = 0;
        while (requests_sent < NUM_ITEMS) begin
            settle();
            case (phase)
                0: cfg = 63;
                1: cfg = 32;
                2: cfg = 0;
                3: cfg = 33;
                default: begin
                    r = $urandom_range(99);
                    if (r < 8) cfg = $urandom_range(0, 1);
                    else if (r < 16) cfg = $urandom_range(33, 63);
                    else if (r < 28) cfg = 32;
                    else cfg = $urandom_range(2, 31);
                end
            endcase
            set_point_count(cfg);
            n = (cfg < 2) ? 2 : ((cfg > MAX_POINTS) ? MAX_POINTS : cfg);
            idle_pct = (requests_sent >= 600 && requests_sent < 900) ? 0 : IDLE_PCT;

            case ($urandom_range(2))
                0: step_max = 64;
                1: step_max = 65536;
                default: step_max = 16777215 / (n - 1);
            endcase
            x = int'($urandom_range(0, 16777215 - step_max * (n - 1))) - 8388608;
            for (int k = 0; k < n; k++) begin
                y = $urandom_range(1) ? rand_coord() : int'($urandom_range(0, 2047)) - 1024;
                put_point(k, x, y);
                step = ($urandom_range(19) == 0) ? 0 : int'($urandom_range(1, step_max));
                x += step;
            end

            nq = $urandom_range(8, 40);
            repeat (nq) begin
                r = $urandom_range(99);
                if (r < 5) begin
                    put_point($urandom_range(0, 31), rand_coord(), rand_coord());
                end else begin
                    seg = $urandom_range(0, n - 2);
                    lo = bp_x_stim[seg];
                    hi = bp_x_stim[seg + 1];
                    r = $urandom_range(99);
                    if (r < 70) px = (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
                    else if (r < 80)
                        px = clamp_coord(bp_x_stim[n - 1] + int'($urandom_range(0, 2)) - 1);
                    else if (r < 88)
                        px = clamp_coord(bp_x_stim[0] + int'($urandom_range(0, 2)) - 1);
                    else px = rand_coord();
                    py = $urandom_range(1) ? rand_coord()
                       : clamp_coord(bp_y_stim[seg] + int'($urandom_range(0, 4096)) - 2048);
                    h = $urandom_range(1) ? int'($urandom_range(0, 8388607))
                      : int'($urandom_range(0, 4096));
                    ask_height(px, py, h);
                end
            end
            phase++;
        end

        // Drain, then watch for stray results
        settle();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
